[rtl/differential_drive_pwm_mixer_macros.svh]
// Assertion helpers used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_PWM_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_PWM_MIXER_MACROS_SVH

// Same-cycle implication
`define DDPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddpm: same-cycle check failed");

// Next-cycle implication
`define DDPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddpm: next-cycle check failed");

`endif

[rtl/ddpm_pkg.sv]
package ddpm_pkg;

  // Field and register widths
  localparam int SPEED_W    = 16;
  localparam int YAW_W      = 16;
  localparam int TRACK_W    = 12;
  localparam int DEADBAND_W = 14;
  localparam int WMAX_W     = 15;
  localparam int PWM_W      = 8;
  localparam int DUTY_W     = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK     = 3'd0,
    CFG_DEADBAND  = 3'd1,
    CFG_WHEEL_MAX = 3'd2,
    CFG_PWM_CEIL  = 3'd3,
    CFG_PWM_FLOOR = 3'd4
  } cfg_idx_t;

  localparam logic [TRACK_W-1:0]    TRACK_RST     = TRACK_W'(200);
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = DEADBAND_W'(20);
  localparam logic [WMAX_W-1:0]     WHEEL_MAX_RST = WMAX_W'(1000);
  localparam logic [PWM_W-1:0]      PWM_CEIL_RST  = PWM_W'(255);
  localparam logic [PWM_W-1:0]      PWM_FLOOR_RST = PWM_W'(0);

  // Yaw term: round(|yaw*track| / 2000) = floor(((|p| + 1000) >> 4) / 125)
  localparam int PROD_W          = YAW_W + TRACK_W + 1;
  localparam int ABS_W           = PROD_W - 1;
  localparam int DELTA_BIAS      = 1000;
  localparam int DELTA_PRE_SHIFT = 4;
  localparam int Y_W             = ABS_W - DELTA_PRE_SHIFT;
  // ceil(2^31 / 125); exact floor for every 24-bit dividend
  localparam int RECIP_W         = 25;
  localparam logic [RECIP_W-1:0] DELTA_RECIP = 25'd17179870;
  localparam int DELTA_SHIFT     = 31;
  localparam int DELTA_W         = 17;
  localparam int QP_W            = DELTA_SHIFT + DELTA_W;

  // Wheel speed and magnitude
  localparam int V_W   = 18;
  localparam int MAG_W = 17;

  // PWM division: num = 2*mag*ceil + wm, den = 2*wm, quotient fits PWM_W
  localparam int NUM_W     = 24;
  localparam int DEN_W     = WMAX_W + 1;
  localparam int DIV_STEPS = PWM_W;

  // Duty scaling: duty = pwm * DUTY_RANGE / 255
  localparam int DUTY_RANGE = 1024;
  localparam int X_W        = $clog2(255 * DUTY_RANGE + 1);
  // ceil(2^32 / 255); exact floor for dividends below 2^24
  localparam logic [RECIP_W-1:0] DUTY_RECIP = 25'd16843010;
  localparam int DUTY_SHIFT = 32;
  localparam int DPROD_W    = DUTY_SHIFT + DUTY_W;

  // Per-wheel flags carried down the pipe
  typedef struct packed {
    logic nz;   // wheel moves (outside deadband)
    logic neg;  // backward
    logic sat;  // |v| at or above wheel max
  } lane_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [PWM_W-1:0] quo;
    lane_t            flag;
  } div_lane_t;

endpackage

[rtl/differential_drive_pwm_mixer.sv]
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+---------------------------------------
// cfg      | in        | cfg_wr_en           | cfg_index, cfg_wdata
// in       | in        | in_valid / in_ready | in_speed_mmps, in_yaw_mradps
// out      | out       | out_valid/out_ready | left/right duty, in1, in2
//
// One word per cycle while the output is not stalled; stages in order: multiply, abs,
// reciprocal, mix, magnitude, numerator, 8 restoring divider steps, PWM limit, duty reciprocal.
// The 8-step PWM divider sets the depth; each step is one compare and subtract.
// A stalled output freezes every stage at once; in_ready = !out_valid | out_ready.
// rst_n (synchronous) clears the valid bits and loads register defaults.
module differential_drive_pwm_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ddpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ddpm_pkg::SPEED_W-1:0] in_speed_mmps,
  input  logic signed [ddpm_pkg::YAW_W-1:0]   in_yaw_mradps,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ddpm_pkg::DUTY_W-1:0]         out_left_duty,
  output logic                                out_left_in1,
  output logic                                out_left_in2,
  output logic [ddpm_pkg::DUTY_W-1:0]         out_right_duty,
  output logic                                out_right_in1,
  output logic                                out_right_in2
);

  localparam int NUM_LANES  = 2;
  localparam int LEFT       = 0;
  localparam int RIGHT      = 1;
  localparam int NUM_STAGES = 8 + ddpm_pkg::DIV_STEPS;

  // Configuration registers
  logic [ddpm_pkg::TRACK_W-1:0]    track_r;
  logic [ddpm_pkg::DEADBAND_W-1:0] deadband_r;
  logic [ddpm_pkg::WMAX_W-1:0]     wheel_max_r;
  logic [ddpm_pkg::PWM_W-1:0]      pwm_ceil_r;
  logic [ddpm_pkg::PWM_W-1:0]      pwm_floor_r;
  logic [ddpm_pkg::WMAX_W-1:0]     wm_eff;
  logic [ddpm_pkg::DEN_W-1:0]      den;

  // Pipeline control
  logic [NUM_STAGES-1:0] valid_r;
  logic                  adv;

  // Stage registers
  logic signed [ddpm_pkg::PROD_W-1:0]  s0_prod_r, s0_prod_nxt;
  logic signed [ddpm_pkg::SPEED_W-1:0] s0_speed_r;
  logic [ddpm_pkg::Y_W-1:0]            s1_y_r, s1_y_nxt;
  logic                                s1_neg_r;
  logic signed [ddpm_pkg::SPEED_W-1:0] s1_speed_r;
  logic [ddpm_pkg::QP_W-1:0]           s2_qprod;
  logic [ddpm_pkg::DELTA_W-1:0]        s2_mdelta_r;
  logic                                s2_neg_r;
  logic signed [ddpm_pkg::SPEED_W-1:0] s2_speed_r;
  logic signed [ddpm_pkg::V_W-1:0]     s3_v_r   [NUM_LANES];
  logic signed [ddpm_pkg::V_W-1:0]     s3_v_nxt [NUM_LANES];
  logic [ddpm_pkg::WMAX_W-1:0]         s4_mag_r   [NUM_LANES];
  logic [ddpm_pkg::WMAX_W-1:0]         s4_mag_nxt [NUM_LANES];
  ddpm_pkg::lane_t                     s4_flag_r   [NUM_LANES];
  ddpm_pkg::lane_t                     s4_flag_nxt [NUM_LANES];
  ddpm_pkg::div_lane_t                 div_r   [ddpm_pkg::DIV_STEPS+1][NUM_LANES];
  ddpm_pkg::div_lane_t                 div_nxt [ddpm_pkg::DIV_STEPS+1][NUM_LANES];
  logic [ddpm_pkg::X_W-1:0]            s14_x_r   [NUM_LANES];
  logic [ddpm_pkg::X_W-1:0]            s14_x_nxt [NUM_LANES];
  logic                                s14_in1_r   [NUM_LANES];
  logic                                s14_in1_nxt [NUM_LANES];
  logic                                s14_in2_r   [NUM_LANES];
  logic                                s14_in2_nxt [NUM_LANES];
  logic [ddpm_pkg::DUTY_W-1:0]         duty_r   [NUM_LANES];
  logic [ddpm_pkg::DUTY_W-1:0]         duty_nxt [NUM_LANES];
  logic                                in1_r [NUM_LANES];
  logic                                in2_r [NUM_LANES];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r     <= ddpm_pkg::TRACK_RST;
      deadband_r  <= ddpm_pkg::DEADBAND_RST;
      wheel_max_r <= ddpm_pkg::WHEEL_MAX_RST;
      pwm_ceil_r  <= ddpm_pkg::PWM_CEIL_RST;
      pwm_floor_r <= ddpm_pkg::PWM_FLOOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ddpm_pkg::CFG_TRACK:     track_r     <= cfg_wdata[ddpm_pkg::TRACK_W-1:0];
        ddpm_pkg::CFG_DEADBAND:  deadband_r  <= cfg_wdata[ddpm_pkg::DEADBAND_W-1:0];
        ddpm_pkg::CFG_WHEEL_MAX: wheel_max_r <= cfg_wdata[ddpm_pkg::WMAX_W-1:0];
        ddpm_pkg::CFG_PWM_CEIL:  pwm_ceil_r  <= cfg_wdata[ddpm_pkg::PWM_W-1:0];
        ddpm_pkg::CFG_PWM_FLOOR: pwm_floor_r <= cfg_wdata[ddpm_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero wheel max acts as 1 mm/s
  assign wm_eff = (wheel_max_r == '0) ? ddpm_pkg::WMAX_W'(1) : wheel_max_r;
  assign den    = {wm_eff, 1'b0};

  // Global stall: all stages move together
  assign adv       = !valid_r[NUM_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // Stage 0: yaw * track
  assign s0_prod_nxt = ddpm_pkg::PROD_W'(in_yaw_mradps)
                     * ddpm_pkg::PROD_W'($signed({1'b0, track_r}));

  // Stage 1: magnitude, rounding bias, divide by 16
  always_comb begin
    logic [ddpm_pkg::PROD_W-1:0] aprod;
    logic [ddpm_pkg::ABS_W-1:0]  biased;
    aprod    = s0_prod_r[ddpm_pkg::PROD_W-1] ? -s0_prod_r : s0_prod_r;
    biased   = aprod[ddpm_pkg::ABS_W-1:0] + ddpm_pkg::ABS_W'(ddpm_pkg::DELTA_BIAS);
    s1_y_nxt = biased[ddpm_pkg::ABS_W-1:ddpm_pkg::DELTA_PRE_SHIFT];
  end

  // Stage 2: divide by 125 through the reciprocal
  assign s2_qprod = ddpm_pkg::QP_W'(s1_y_r) * ddpm_pkg::QP_W'(ddpm_pkg::DELTA_RECIP);

  // Stage 3: mix into left and right wheel speeds
  always_comb begin
    logic signed [ddpm_pkg::V_W-1:0] sp;
    logic signed [ddpm_pkg::V_W-1:0] md;
    sp = ddpm_pkg::V_W'(s2_speed_r);
    md = $signed(ddpm_pkg::V_W'(s2_mdelta_r));
    s3_v_nxt[LEFT]  = s2_neg_r ? sp + md : sp - md;
    s3_v_nxt[RIGHT] = s2_neg_r ? sp - md : sp + md;
  end

  // Stage 4: magnitude, deadband and saturation tests
  always_comb begin
    logic [ddpm_pkg::V_W-1:0]   av;
    logic [ddpm_pkg::MAG_W-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      av  = s3_v_r[l][ddpm_pkg::V_W-1] ? -s3_v_r[l] : s3_v_r[l];
      mag = av[ddpm_pkg::MAG_W-1:0];
      s4_flag_nxt[l].neg = s3_v_r[l][ddpm_pkg::V_W-1];
      s4_flag_nxt[l].nz  = (s3_v_r[l] != '0)
                        && (mag >= ddpm_pkg::MAG_W'(deadband_r));
      s4_flag_nxt[l].sat = mag >= ddpm_pkg::MAG_W'(wm_eff);
      s4_mag_nxt[l]      = s4_flag_nxt[l].sat ? '0 : mag[ddpm_pkg::WMAX_W-1:0];
    end
  end

  // Stage 5: divider numerator; then one quotient bit per stage
  always_comb begin
    logic [ddpm_pkg::NUM_W-1:0] dsh;
    int                         b;
    for (int l = 0; l < NUM_LANES; l++) begin
      div_nxt[0][l].rem  = ((ddpm_pkg::NUM_W'(s4_mag_r[l])
                          * ddpm_pkg::NUM_W'(pwm_ceil_r)) << 1)
                         + ddpm_pkg::NUM_W'(wm_eff);
      div_nxt[0][l].quo  = '0;
      div_nxt[0][l].flag = s4_flag_r[l];
    end
    for (int k = 0; k < ddpm_pkg::DIV_STEPS; k++) begin
      b = ddpm_pkg::DIV_STEPS - 1 - k;
      for (int l = 0; l < NUM_LANES; l++) begin
        dsh = ddpm_pkg::NUM_W'(den) << b;
        div_nxt[k+1][l] = div_r[k][l];
        if (div_r[k][l].rem >= dsh) begin
          div_nxt[k+1][l].rem    = div_r[k][l].rem - dsh;
          div_nxt[k+1][l].quo[b] = 1'b1;
        end
      end
    end
  end

  // Stage 14: saturation, minimum effective PWM, ceiling clamp
  always_comb begin
    ddpm_pkg::div_lane_t       q;
    logic [ddpm_pkg::PWM_W-1:0] pwm;
    for (int l = 0; l < NUM_LANES; l++) begin
      q   = div_r[ddpm_pkg::DIV_STEPS][l];
      pwm = q.flag.sat ? pwm_ceil_r : q.quo;
      if (pwm != '0 && pwm < pwm_floor_r) begin
        pwm = pwm_floor_r;
      end
      if (pwm > pwm_ceil_r) begin
        pwm = pwm_ceil_r;
      end
      s14_x_nxt[l]   = q.flag.nz ? ddpm_pkg::X_W'(pwm) * ddpm_pkg::X_W'(ddpm_pkg::DUTY_RANGE)
                                 : '0;
      s14_in1_nxt[l] = q.flag.nz && q.flag.neg;
      s14_in2_nxt[l] = q.flag.nz && !q.flag.neg;
    end
  end

  // Stage 15: divide by 255 through the reciprocal
  always_comb begin
    logic [ddpm_pkg::DPROD_W-1:0] dp;
    for (int l = 0; l < NUM_LANES; l++) begin
      dp          = ddpm_pkg::DPROD_W'(s14_x_r[l]) * ddpm_pkg::DPROD_W'(ddpm_pkg::DUTY_RECIP);
      duty_nxt[l] = dp[ddpm_pkg::DUTY_SHIFT +: ddpm_pkg::DUTY_W];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_prod_r   <= s0_prod_nxt;
      s0_speed_r  <= in_speed_mmps;
      s1_y_r      <= s1_y_nxt;
      s1_neg_r    <= s0_prod_r[ddpm_pkg::PROD_W-1];
      s1_speed_r  <= s0_speed_r;
      s2_mdelta_r <= s2_qprod[ddpm_pkg::DELTA_SHIFT +: ddpm_pkg::DELTA_W];
      s2_neg_r    <= s1_neg_r;
      s2_speed_r  <= s1_speed_r;
      for (int l = 0; l < NUM_LANES; l++) begin
        s3_v_r[l]    <= s3_v_nxt[l];
        s4_mag_r[l]  <= s4_mag_nxt[l];
        s4_flag_r[l] <= s4_flag_nxt[l];
        for (int k = 0; k <= ddpm_pkg::DIV_STEPS; k++) begin
          div_r[k][l] <= div_nxt[k][l];
        end
        s14_x_r[l]   <= s14_x_nxt[l];
        s14_in1_r[l] <= s14_in1_nxt[l];
        s14_in2_r[l] <= s14_in2_nxt[l];
        duty_r[l]    <= duty_nxt[l];
        in1_r[l]     <= s14_in1_r[l];
        in2_r[l]     <= s14_in2_r[l];
      end
    end
  end

  assign out_left_duty  = duty_r[LEFT];
  assign out_left_in1   = in1_r[LEFT];
  assign out_left_in2   = in2_r[LEFT];
  assign out_right_duty = duty_r[RIGHT];
  assign out_right_in1  = in1_r[RIGHT];
  assign out_right_in2  = in2_r[RIGHT];

endmodule

[rtl/ddpm_checker.sv]
`include "differential_drive_pwm_mixer_macros.svh"

module ddpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ddpm_pkg::DUTY_W-1:0] out_left_duty,
  input logic                        out_left_in1,
  input logic                        out_left_in2,
  input logic [ddpm_pkg::DUTY_W-1:0] out_right_duty,
  input logic                        out_right_in1,
  input logic                        out_right_in2
);

  logic pins_ok;
  logic duty_ok;
  logic out_stall;

  // Never drive both bridge inputs of a wheel high
  assign pins_ok = !(out_left_in1 && out_left_in2) && !(out_right_in1 && out_right_in2);

  // A stopped wheel has zero duty
  assign duty_ok = (out_left_in1 || out_left_in2 || out_left_duty == '0)
                && (out_right_in1 || out_right_in2 || out_right_duty == '0);

  assign out_stall = out_valid && !out_ready;

  `DDPM_ASSERT_SAME(a_pins_exclusive, out_valid, pins_ok)
  `DDPM_ASSERT_SAME(a_stop_zero_duty, out_valid, duty_ok)

  // A stalled output blocks the input; an empty output never does
  `DDPM_ASSERT_SAME(a_stall_blocks_in, out_stall, !in_ready)
  `DDPM_ASSERT_SAME(a_empty_takes_in, !out_valid, in_ready)

  // A stalled output stays valid and its duty values hold
  `DDPM_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({out_left_duty, out_right_duty}))

endmodule

bind differential_drive_pwm_mixer ddpm_checker u_ddpm_checker (.*);
